// ----- hdl/shr_pkg.sv -----
// Shared types and constants for the selection hit recorder.
// No dependencies; imported by shr_front, shr_back and the top level.
package shr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 31;
  localparam int unsigned QDEPTH = 2;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_PUSH = 3'd1;
  localparam logic [2:0] OP_POP  = 3'd2;
  localparam logic [2:0] OP_LOAD = 3'd3;
  localparam logic [2:0] OP_HIT  = 3'd4;
  localparam logic [2:0] OP_MODE = 3'd5;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [1:0] ERR_LOAD      = 2'd3;

  localparam logic [1:0] HDR_COUNT = 2'd0;
  localparam logic [1:0] HDR_MIN   = 2'd1;
  localparam logic [1:0] HDR_MAX   = 2'd2;

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_PUSH,
    CMD_POP,
    CMD_LOAD,
    CMD_HIT,
    CMD_MODE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [WORD_W-1:0]   name;
    logic [WORD_W-1:0]   dlo;
    logic [WORD_W-1:0]   dhi;
    logic                sel;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_NAMES,
    S_STATUS
  } back_state_t;

  function automatic cmd_kind_t decode_op(input logic [2:0] op);
    cmd_kind_t k;
    unique case (op)
      OP_INIT: k = CMD_INIT;
      OP_PUSH: k = CMD_PUSH;
      OP_POP:  k = CMD_POP;
      OP_LOAD: k = CMD_LOAD;
      OP_HIT:  k = CMD_HIT;
      OP_MODE: k = CMD_MODE;
      default: k = CMD_NOP;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/shr_front.sv -----
// Front end: accepts commands, decodes the opcode and holds them in a
// two-entry queue for the back end. Depends on shr_pkg.
module shr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            opcode,
  input  logic [31:0]           name_value,
  input  logic [31:0]           depth_low,
  input  logic [31:0]           depth_high,
  input  logic                  select_on,
  output logic                  q_valid,
  output shr_pkg::cmd_t         q_cmd,
  input  logic                  q_pop
);
  import shr_pkg::*;

  cmd_t       entries [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign in_ready = (fill != 2'(QDEPTH));
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    in_cmd.kind = decode_op(opcode);
    in_cmd.name = name_value;
    in_cmd.dlo  = depth_low;
    in_cmd.dhi  = depth_high;
    in_cmd.sel  = select_on;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/shr_back.sv -----
// Back end: name stack, pending hit, select buffer bookkeeping and the
// flush sequencer that emits one buffer word per cycle unless the output stalls. Depends on shr_pkg.
module shr_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  shr_pkg::cmd_t         q_cmd,
  output logic                  q_pop,
  input  logic                  cfg_we,
  input  logic [30:0]           cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [30:0]           word_index,
  output logic [31:0]           word_value,
  output logic [1:0]            error_code,
  output logic signed [31:0]    mode_result,
  output logic                  last
);
  import shr_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [IDX_W-1:0] CNT_MAX = {IDX_W{1'b1}};

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cmd;
  logic [1:0]        step;
  logic [CW-1:0]     name_idx;
  logic [CW-1:0]     name_idx_next;
  logic [CW-1:0]     stack_count;
  logic              selecting;
  logic              hit_armed;
  logic [31:0]       pending_min;
  logic [31:0]       pending_max;
  logic [IDX_W-1:0]  words_written;
  logic [IDX_W-1:0]  hit_count;
  logic              overflowed;
  logic [IDX_W-1:0]  capacity;

  logic [31:0]       name_mem [STACK_DEPTH];
  logic [31:0]       rd_data;
  logic [AW-1:0]     wr_addr;
  logic              mem_we;

  logic              slot_free;
  logic              word_ok;
  logic              need_flush;
  logic              word_go;
  logic              word_emit;
  logic              status_go;
  logic [31:0]       cur_word;
  logic [1:0]        err;
  logic [31:0]       mres;
  logic              stack_full;
  logic              stack_empty;

  assign slot_free   = !out_valid || out_ready;
  assign word_ok     = (words_written < capacity);
  assign stack_full  = (stack_count >= DEPTH_C);
  assign stack_empty = (stack_count == '0);

  always_comb begin
    unique case (q_cmd.kind)
      CMD_INIT, CMD_PUSH, CMD_POP, CMD_LOAD: need_flush = hit_armed;
      CMD_MODE: need_flush = hit_armed && selecting;
      default:  need_flush = 1'b0;
    endcase
  end

  always_comb begin
    if (state == S_NAMES) begin
      cur_word = rd_data;
    end else begin
      unique case (step)
        HDR_COUNT: cur_word = 32'(stack_count);
        HDR_MIN:   cur_word = pending_min;
        default:   cur_word = pending_max;
      endcase
    end
  end

  // Status fields come from state as it stands after any flush.
  always_comb begin
    err  = ERR_NONE;
    mres = '0;
    unique case (cmd.kind)
      CMD_PUSH: if (stack_full)  err = ERR_OVERFLOW;
      CMD_POP:  if (stack_empty) err = ERR_UNDERFLOW;
      CMD_LOAD: if (stack_empty) err = ERR_LOAD;
      CMD_MODE: if (selecting) mres = overflowed ? '1 : {1'b0, hit_count};
      default:  ;
    endcase
  end

  always_comb begin
    state_next    = state;
    name_idx_next = name_idx;
    q_pop         = 1'b0;
    word_go       = 1'b0;
    word_emit     = 1'b0;
    status_go     = 1'b0;
    unique case (state)
      S_IDLE: begin
        name_idx_next = '0;
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = need_flush ? S_HDR : S_STATUS;
        end
      end
      S_HDR: begin
        // a word past capacity is dropped and needs no output slot
        if (!word_ok || slot_free) begin
          word_go   = 1'b1;
          word_emit = word_ok;
          if (step == HDR_MAX) begin
            state_next = stack_empty ? S_STATUS : S_NAMES;
          end
        end
      end
      S_NAMES: begin
        if (!word_ok || slot_free) begin
          word_go   = 1'b1;
          word_emit = word_ok;
          if (name_idx + 1'b1 == stack_count) begin
            state_next = S_STATUS;
          end else begin
            name_idx_next = name_idx + 1'b1;
          end
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          status_go  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign mem_we  = status_go &&
                   ((cmd.kind == CMD_PUSH && !stack_full) ||
                    (cmd.kind == CMD_LOAD && !stack_empty));
  assign wr_addr = (cmd.kind == CMD_PUSH) ? stack_count[AW-1:0]
                                          : AW'(stack_count - 1'b1);

  // Read data tracks name_idx with no lag: address with its next value.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      name_mem[wr_addr] <= cmd.name;
    end
    rd_data <= name_mem[name_idx_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    name_idx <= name_idx_next;
    if (q_pop) begin
      cmd  <= q_cmd;
      step <= HDR_COUNT;
    end else if (word_go && state == S_HDR) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      selecting     <= 1'b0;
      hit_armed     <= 1'b0;
      pending_min   <= '0;
      pending_max   <= '0;
      words_written <= '0;
      hit_count     <= '0;
      overflowed    <= 1'b0;
    end else begin
      if (q_pop && need_flush) begin
        hit_armed <= 1'b0;
        if (hit_count != CNT_MAX) begin
          hit_count <= hit_count + 1'b1;
        end
      end
      if (word_go) begin
        if (word_emit) begin
          words_written <= words_written + 1'b1;
        end else begin
          overflowed <= 1'b1;
        end
      end
      if (status_go) begin
        unique case (cmd.kind)
          CMD_INIT: stack_count <= '0;
          CMD_PUSH: if (!stack_full)  stack_count <= stack_count + 1'b1;
          CMD_POP:  if (!stack_empty) stack_count <= stack_count - 1'b1;
          CMD_HIT: begin
            if (selecting) begin
              if (!hit_armed) begin
                hit_armed   <= 1'b1;
                pending_min <= cmd.dlo;
                pending_max <= cmd.dhi;
              end else begin
                if (cmd.dlo < pending_min) pending_min <= cmd.dlo;
                if (cmd.dhi > pending_max) pending_max <= cmd.dhi;
              end
            end
          end
          CMD_MODE: begin
            selecting     <= cmd.sel;
            words_written <= '0;
            hit_count     <= '0;
            overflowed    <= 1'b0;
            hit_armed     <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_emit || status_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_emit) begin
      kind        <= 1'b0;
      word_index  <= words_written;
      word_value  <= cur_word;
      error_code  <= ERR_NONE;
      mode_result <= '0;
      last        <= 1'b0;
    end else if (status_go) begin
      kind        <= 1'b1;
      word_index  <= '0;
      word_value  <= '0;
      error_code  <= err;
      mode_result <= mres;
      last        <= 1'b1;
    end
  end

endmodule

// ----- hdl/selection_hit_recorder.sv -----
// Per command the back end takes it from the queue, then registers its status;
// it takes no new command until that status is registered. A flush first emits the
// stack count, min, max and each name in use, one buffer word per cycle unless stalled.
// A two-entry command queue lets input transfers continue while results stall.
// Reset clears the state machine, queue pointers, counters, flags and the capacity
// register; the name stack contents and the output data fields are not cleared.
module selection_hit_recorder #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            opcode,
  input  logic [31:0]           name_value,
  input  logic [31:0]           depth_low,
  input  logic [31:0]           depth_high,
  input  logic                  select_on,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [30:0]           word_index,
  output logic [31:0]           word_value,
  output logic [1:0]            error_code,
  output logic signed [31:0]    mode_result,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic [30:0]           cfg_wdata
);
  import shr_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  shr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .name_value (name_value),
    .depth_low  (depth_low),
    .depth_high (depth_high),
    .select_on  (select_on),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  shr_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .word_index  (word_index),
    .word_value  (word_value),
    .error_code  (error_code),
    .mode_result (mode_result),
    .last        (last)
  );

endmodule

// ----- verif/tb_selection_hit_recorder.sv -----
// Self-checking testbench for selection_hit_recorder: directed command sequences, then
// random traffic with random stalls on both channels, checked against a local model.
// Depends on shr_pkg and the selection_hit_recorder RTL.
`timescale 1ns / 1ps

module tb_selection_hit_recorder;
  import shr_pkg::*;

  localparam int unsigned STACK_DEPTH    = 32;
  localparam logic [2:0]  OP_UNUSED6     = 3'd6;
  localparam logic [2:0]  OP_UNUSED7     = 3'd7;
  localparam logic [30:0] CAPACITY_MAX   = 31'h7FFF_FFFF;
  localparam logic [30:0] HIT_COUNT_MAX  = 31'h7FFF_FFFF;
  localparam int          RANDOM_ITEMS   = 165;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          END_CYCLES     = 60;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        kind;
    logic [30:0] word_idx;
    logic [31:0] value;
    logic [1:0]  err;
    logic [31:0] mres;
    logic        last;
  } buffer_record_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [31:0] name_value;
  logic [31:0] depth_low;
  logic [31:0] depth_high;
  logic        select_on;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [30:0] word_index;
  logic [31:0] word_value;
  logic [1:0]  error_code;
  logic signed [31:0] mode_result;
  logic        last;
  logic        cfg_we;
  logic [30:0] cfg_wdata;

  selection_hit_recorder #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .name_value (name_value),
    .depth_low  (depth_low),
    .depth_high (depth_high),
    .select_on  (select_on),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .word_index (word_index),
    .word_value (word_value),
    .error_code (error_code),
    .mode_result(mode_result),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Local copy of the recorder state
  logic [31:0]    name_mem [STACK_DEPTH];
  int unsigned    stack_count;
  logic           selecting;
  logic           hit_armed;
  logic [31:0]    pending_min;
  logic [31:0]    pending_max;
  logic [30:0]    words_written;
  logic [30:0]    hit_count;
  logic           overflowed;
  logic [30:0]    buffer_capacity;

  buffer_record_t expected_records [$];
  int             mismatches;
  int             idle_cycles;
  int             hold_request;
  int             ready_hold_left;
  int             ready_run_left;
  bit             sender_no_gaps;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic emit_word(input logic [31:0] value);
    buffer_record_t rec;
    if (words_written < buffer_capacity) begin
      rec = '{kind: 1'b0, word_idx: words_written, value: value, err: ERR_NONE,
              mres: '0, last: 1'b0};
      expected_records.insert(expected_records.size(), rec);
      words_written++;
    end else begin
      overflowed = 1'b1;
    end
  endtask

  task automatic flush_pending_hit();
    if (hit_armed) begin
      hit_armed = 1'b0;
      if (hit_count < HIT_COUNT_MAX) hit_count++;
      emit_word(32'(stack_count));
      emit_word(pending_min);
      emit_word(pending_max);
      for (int i = 0; i < stack_count; i++) emit_word(name_mem[i]);
    end
  endtask

  task automatic model_command(input logic [2:0] op, input logic [31:0] name,
                               input logic [31:0] dlo, input logic [31:0] dhi,
                               input logic sel);
    logic [1:0]     err;
    logic [31:0]    mres;
    buffer_record_t rec;
    err  = ERR_NONE;
    mres = '0;
    case (op)
      OP_INIT: begin
        flush_pending_hit();
        stack_count = 0;
      end
      OP_PUSH: begin
        flush_pending_hit();
        if (stack_count >= STACK_DEPTH) begin
          err = ERR_OVERFLOW;
        end else begin
          name_mem[stack_count] = name;
          stack_count++;
        end
      end
      OP_POP: begin
        flush_pending_hit();
        if (stack_count == 0) err = ERR_UNDERFLOW;
        else stack_count--;
      end
      OP_LOAD: begin
        flush_pending_hit();
        if (stack_count == 0) err = ERR_LOAD;
        else name_mem[stack_count-1] = name;
      end
      OP_HIT: begin
        if (selecting) begin
          if (!hit_armed) begin
            hit_armed   = 1'b1;
            pending_min = dlo;
            pending_max = dhi;
          end else begin
            if (dlo < pending_min) pending_min = dlo;
            if (dhi > pending_max) pending_max = dhi;
          end
        end
      end
      OP_MODE: begin
        if (selecting) begin
          flush_pending_hit();
          mres = overflowed ? 32'hFFFF_FFFF : {1'b0, hit_count};
        end
        selecting     = sel;
        words_written = '0;
        hit_count     = '0;
        overflowed    = 1'b0;
        hit_armed     = 1'b0;
      end
      default: begin
      end
    endcase
    rec = '{kind: 1'b1, word_idx: '0, value: '0, err: err, mres: mres, last: 1'b1};
    expected_records.insert(expected_records.size(), rec);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] random_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0000_0000;
    if (r < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_command(input logic [2:0] op, input logic [31:0] name,
                              input logic [31:0] dlo, input logic [31:0] dhi,
                              input logic sel);
    int gap;
    gap = sender_no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    name_value <= name;
    depth_low  <= dlo;
    depth_high <= dhi;
    select_on  <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_command(op, name, dlo, dhi, sel);
  endtask

  // Shorthands for directed sequences; unused fields carry random data
  task automatic send_op(input logic [2:0] op);
    send_command(op, $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic send_name(input logic [2:0] op, input logic [31:0] name);
    send_command(op, name, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic send_hit(input logic [31:0] dlo, input logic [31:0] dhi);
    send_command(OP_HIT, $urandom, dlo, dhi, 1'($urandom));
  endtask

  task automatic send_mode(input logic sel);
    send_command(OP_MODE, $urandom, $urandom, $urandom, sel);
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [30:0] value);
    drain_block();
    cfg_we          <= 1'b1;
    cfg_wdata       <= value;
    buffer_capacity  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_idle_commands();
    send_op(OP_POP);
    send_name(OP_LOAD, 32'hFFFF_FFFF);
    send_op(OP_UNUSED6);
    send_op(OP_UNUSED7);
    send_hit(32'h0000_0000, 32'hFFFF_FFFF);
    send_mode(1'b0);
  endtask

  task automatic test_zero_capacity();
    set_capacity('0);
    send_mode(1'b1);
    send_hit(32'h1234_5678, 32'h9ABC_DEF0);
    send_name(OP_PUSH, 32'h0000_0000);
    send_mode(1'b0);
  endtask

  task automatic test_depth_extremes();
    set_capacity(CAPACITY_MAX);
    send_mode(1'b1);
    send_name(OP_PUSH, 32'hFFFF_FFFF);
    send_hit(32'h0000_0000, 32'hFFFF_FFFF);
    send_hit(32'h0000_0005, 32'h0000_0007);
    send_name(OP_LOAD, 32'hA5A5_5A5A);
    // first hit after a flush takes both bounds directly
    send_hit(32'hFFFF_FFFF, 32'h0000_0000);
    send_hit(32'h0000_0010, 32'h0000_0020);
    send_op(OP_POP);
    send_op(OP_INIT);
    send_mode(1'b0);
  endtask

  task automatic test_exact_capacity();
    set_capacity(31'd5);
    send_mode(1'b1);
    send_name(OP_PUSH, $urandom);
    send_name(OP_PUSH, $urandom);
    send_hit($urandom, $urandom);
    send_name(OP_PUSH, $urandom);
    send_hit($urandom, $urandom);
    send_op(OP_INIT);
    // grow the buffer mid-selection; overflow stays latched
    set_capacity(31'd12);
    send_name(OP_PUSH, $urandom);
    send_hit($urandom, $urandom);
    send_op(OP_POP);
    send_mode(1'b0);
  endtask

  task automatic test_stack_full();
    set_capacity(CAPACITY_MAX);
    send_mode(1'b1);
    send_op(OP_INIT);
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (i == STACK_DEPTH - 1) send_hit(random_depth(), random_depth());
      send_name(OP_PUSH, $urandom);
    end
    send_name(OP_PUSH, $urandom);
    send_hit(random_depth(), random_depth());
    send_name(OP_PUSH, $urandom);
    send_op(OP_POP);
    send_name(OP_LOAD, $urandom);
    send_mode(1'b0);
  endtask

  task automatic test_backpressure();
    set_capacity(CAPACITY_MAX);
    send_mode(1'b1);
    hold_request   = HOLD_CYCLES;
    sender_no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_hit(random_depth(), random_depth());
      send_name(OP_PUSH, $urandom);
    end
    sender_no_gaps = 1'b0;
    send_mode(1'b0);
  endtask

  task automatic test_random_traffic();
    int          counted;
    int          phase_items;
    int          r;
    logic [2:0]  op;
    logic [31:0] dlo;
    logic [31:0] dhi;
    logic        sel;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) set_capacity('0);
      else if (r < 25) set_capacity(CAPACITY_MAX);
      else if (r < 35) set_capacity(31'($urandom));
      else set_capacity(31'($urandom_range(1, 80)));
      if (!selecting && $urandom_range(0, 99) < 85) begin
        send_mode(1'b1);
        counted++;
      end
      phase_items = $urandom_range(30, 50);
      for (int i = 0; i < phase_items && counted < RANDOM_ITEMS; i++) begin
        r   = $urandom_range(0, 99);
        dlo = random_depth();
        dhi = random_depth();
        sel = 1'($urandom);
        if (r < 35) begin
          op = OP_HIT;
          // mostly well-formed ranges
          if (dlo > dhi && $urandom_range(0, 99) < 80) {dlo, dhi} = {dhi, dlo};
        end else if (r < 55) op = OP_PUSH;
        else if (r < 65) op = OP_POP;
        else if (r < 75) op = OP_LOAD;
        else if (r < 80) op = OP_INIT;
        else if (r < 90) begin
          op  = OP_MODE;
          sel = ($urandom_range(0, 99) < 70);
        end else if (r < 95) op = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
        else op = 3'($urandom_range(0, 7));
        counted++;
        send_command(op, $urandom, dlo, dhi, sel);
      end
    end
  endtask

  // Receiver: runs of ready, short and occasional long stalls, plus requested holds
  always @(negedge clk) begin
    int pick;
    if (hold_request > 0) begin
      ready_hold_left = hold_request;
      ready_run_left  = 0;
      hold_request    = 0;
    end
    if (ready_hold_left == 0 && ready_run_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) ready_run_left = $urandom_range(4, 40);
      else if (pick < 93) ready_hold_left = $urandom_range(1, 3);
      else ready_hold_left = $urandom_range(12, 40);
    end
    if (ready_hold_left > 0) begin
      out_ready <= 1'b0;
      ready_hold_left--;
    end else begin
      out_ready <= 1'b1;
      ready_run_left--;
    end
  end

  always @(posedge clk) begin
    buffer_record_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        report_mismatch("result with nothing expected", word_value, '0);
      end else begin
        want = expected_records.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (word_index !== want.word_idx)
          report_mismatch("word_index", 32'(word_index), 32'(want.word_idx));
        if (word_value !== want.value) report_mismatch("word_value", word_value, want.value);
        if (error_code !== want.err)
          report_mismatch("error_code", 32'(error_code), 32'(want.err));
        if (mode_result !== want.mres) report_mismatch("mode_result", mode_result, want.mres);
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("selection_hit_recorder verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    opcode          = OP_INIT;
    name_value      = '0;
    depth_low       = '0;
    depth_high      = '0;
    select_on       = 1'b0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    mismatches      = 0;
    idle_cycles     = 0;
    hold_request    = 0;
    ready_hold_left = 0;
    ready_run_left  = 0;
    sender_no_gaps  = 1'b0;
    stack_count     = 0;
    selecting       = 1'b0;
    hit_armed       = 1'b0;
    pending_min     = '0;
    pending_max     = '0;
    words_written   = '0;
    hit_count       = '0;
    overflowed      = 1'b0;
    buffer_capacity = '0;
    foreach (name_mem[i]) name_mem[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_zero_capacity();
    test_depth_extremes();
    test_exact_capacity();
    test_stack_full();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("selection_hit_recorder verification clean");
    end else begin
      $display("selection_hit_recorder verification failed");
    end
    $finish;
  end

endmodule
